// File: rtl/prle_pkg.sv
// types shared by the packbits-style run-length decoder
// compressed byte item in, decoded result item out; no dependencies
package prle_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] copies;
        logic       truncated;
        logic       last;
    } t_out;

    // header byte at or above this value announces a repeat run
    localparam logic [7:0] REPEAT_MIN = 8'd128;
    // repeat run copy count is header minus this offset
    localparam logic [7:0] REPEAT_OFFSET = 8'd126;

endpackage

// File: rtl/prle_step.sv
// decode step of the run-length decoder: phase and counter registers
// plus the logic that turns one compressed byte into zero or one result; uses prle_pkg
module prle_step
    import prle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    output logic o_has_result,
    output t_out o_result
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_REPEAT  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_lit_left, n_lit_left;
    logic [7:0] r_rep_cnt, n_rep_cnt;
    logic [7:0] lit_dec;

    assign lit_dec = r_lit_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_lit_left   = r_lit_left;
        n_rep_cnt    = r_rep_cnt;
        o_has_result = 1'b1;
        o_result     = '0;
        o_result.last = i_item.stream_end;
        unique case (r_phase)
            PH_REPEAT: begin
                o_result.value  = i_item.data_byte;
                o_result.copies = r_rep_cnt;
                n_rep_cnt       = '0;
                n_phase         = PH_HEADER;
            end
            PH_LITERAL: begin
                o_result.value  = i_item.data_byte;
                o_result.copies = 8'd1;
                n_lit_left      = lit_dec;
                if (lit_dec == '0) begin
                    n_phase = PH_HEADER;
                end else begin
                    o_result.truncated = i_item.stream_end;
                end
            end
            default: begin
                if (i_item.data_byte < REPEAT_MIN) begin
                    n_lit_left = i_item.data_byte + 8'd1;
                    n_phase    = PH_LITERAL;
                end else begin
                    n_rep_cnt = i_item.data_byte - REPEAT_OFFSET;
                    n_phase   = PH_REPEAT;
                end
                // a header only yields a status result when the stream stops on it
                o_has_result       = i_item.stream_end;
                o_result.truncated = 1'b1;
            end
        endcase
        if (i_item.stream_end) begin
            n_phase    = PH_HEADER;
            n_lit_left = '0;
            n_rep_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_lit_left <= '0;
            r_rep_cnt  <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_rep_cnt  <= n_rep_cnt;
        end
    end

    a_lit_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LITERAL |-> r_lit_left != 8'd0)
        else $error("literal phase with no bytes left");

    a_end_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.stream_end |=> r_phase == PH_HEADER && r_rep_cnt == 8'd0)
        else $error("state not cleared after final byte");

    a_status_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_has_result && o_result.copies == 8'd0
            |-> o_result.truncated && o_result.last)
        else $error("status-only result without truncation at stream end");

    a_repeat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_REPEAT |-> r_rep_cnt >= 8'd2 && r_rep_cnt <= 8'd129)
        else $error("repeat count out of range");

endmodule

// File: rtl/packbits_style_rle_decoder_unit.sv
// Packbits-style run-length decoder: takes one compressed byte per cycle unless a
// result is held by a stalled output, and gives zero or one result per byte: a literal
// byte with copies 1, a repeat value with its copy count, or a status result with
// copies 0 when the stream ends on a header; expanding repeats is left downstream.
// Each byte is held in an input register, decoded by the step logic and written to a
// result register, and a new byte can be taken every cycle while the output drains.
// Rate is set by the phase and counter update; uses prle_pkg, prle_step.
module packbits_style_rle_decoder_unit
    import prle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;

    logic out_free;
    logic adv;
    logic has_result;
    t_out result;

    prle_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (adv),
        .i_item       (r_in),
        .o_has_result (has_result),
        .o_result     (result)
    );

    assign out_free   = !r_out_vld || i_out_ready;
    // a byte that yields no result never waits on the output side
    assign adv        = r_in_vld && (out_free || !has_result);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && has_result) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
